// ===== hw/rtl/utf8_byte_sanitizer_macros.svh =====
// Assertion macros for the utf-8 byte sanitizer.
// Included by the top level; expects clk and rst in scope.
`ifndef UTF8_BYTE_SANITIZER_MACROS_SVH
`define UTF8_BYTE_SANITIZER_MACROS_SVH

// Implication checked every cycle outside reset.
`define UBS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ubs assertion failed");

// Condition that must hold in the cycle after reset.
`define UBS_ASSERT_AFTER_RESET(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("ubs reset assertion failed");

`endif

// ===== hw/rtl/ubs_pkg.sv =====
// Shared types and constants of the utf-8 byte sanitizer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package ubs_pkg;

  localparam logic [7:0] HIGH_BIT_MASK = 8'h80;
  localparam logic [7:0] CONT_MASK     = 8'hC0;
  localparam logic [7:0] CONT_CODE     = 8'h80;
  localparam logic [7:0] LEAD2_MASK    = 8'hE0;
  localparam logic [7:0] LEAD2_CODE    = 8'hC0;
  localparam logic [7:0] LEAD3_MASK    = 8'hF0;
  localparam logic [7:0] LEAD3_CODE    = 8'hE0;
  localparam logic [7:0] LEAD4_MASK    = 8'hF8;
  localparam logic [7:0] LEAD4_CODE    = 8'hF0;
  localparam logic [7:0] REPL_RESET    = 8'h3F;

  // One classified item: reps replacement bytes, then lit_count literal
  // bytes, then optionally the end result.
  typedef struct packed {
    logic [2:0]      reps;
    logic [2:0]      lit_count;
    logic [3:0][7:0] lits;
    logic            end_res;
    logic            any;
  } cmd_t;

endpackage

// ===== hw/rtl/utf8_byte_sanitizer.sv =====
// Top level of the utf-8 byte sanitizer: replacement register, front end,
// command queue and back end. Depends on ubs_pkg and the macros header.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    in_byte, end_of_string
//   out      output     out_valid / out_stall  out_byte, is_end, any_replaced
//   cfg      input      cfg_valid / cfg_ready  cfg_data (replacement byte)
//
// One input item is taken per cycle while the two-entry queue has room.
// Results leave the back end one per cycle unless out_stall holds them.
// An item yields 0 to 4. The input stalls only once both queue entries wait,
// behind a command with several results or behind a stalled output register.
// Reset (rst, synchronous) clears the run state and empties the queue.
// Stalls on either side are absorbed by the queue and the output register.
`timescale 1ns / 1ps
`include "utf8_byte_sanitizer_macros.svh"

module utf8_byte_sanitizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       end_of_string,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       is_end,
  output logic       any_replaced,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);
  import ubs_pkg::*;

  logic [7:0] replacement_byte;
  logic       q_full;
  logic       push;
  cmd_t       push_cmd;
  logic       head_valid;
  cmd_t       head_cmd;
  logic       pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      replacement_byte <= REPL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      replacement_byte <= cfg_data;
    end
  end

  ubs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_byte       (in_byte),
    .end_of_string (end_of_string),
    .q_full        (q_full),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  ubs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop)
  );

  ubs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .repl_byte    (replacement_byte),
    .head_valid   (head_valid),
    .head_cmd     (head_cmd),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .is_end       (is_end),
    .any_replaced (any_replaced)
  );

  `UBS_ASSERT_IMPL(a_end_carries_no_byte, out_valid && is_end, out_byte == 8'h00)
  `UBS_ASSERT_IMPL(a_flag_only_on_end, out_valid && !is_end, !any_replaced)
  `UBS_ASSERT_IMPL(a_pop_needs_head, pop, head_valid)
  `UBS_ASSERT_AFTER_RESET(a_ready_after_reset, !in_stall && !out_valid)

endmodule

// ===== hw/rtl/ubs_front.sv =====
// Front end: accepts bytes, tracks pending multi-byte runs, and classifies
// each item into a command for the queue. Depends on ubs_pkg.
`timescale 1ns / 1ps

module ubs_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_byte,
  input  logic          end_of_string,
  input  logic          q_full,
  output logic          push,
  output ubs_pkg::cmd_t push_cmd
);
  import ubs_pkg::*;

  logic [7:0]      lead_held;
  logic [1:0][7:0] cont_bytes;
  logic [1:0]      run_needed;
  logic [1:0]      run_have;
  logic            pending_valid;
  logic            replaced_flag;

  logic [7:0] lead_held_next;
  logic [1:0] run_needed_next;
  logic [1:0] run_have_next;
  logic       pending_valid_next;
  logic       replaced_flag_next;
  logic       cont_write;
  cmd_t       cmd;
  logic       accept;
  logic       is_cont;
  logic [2:0] flush_reps;
  logic [1:0] fresh_run;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign is_cont  = (in_byte & CONT_MASK) == CONT_CODE;
  assign flush_reps = pending_valid ? ({1'b0, run_have} + 3'd1) : 3'd0;

  always_comb begin
    fresh_run = 2'd0;
    if ((in_byte & LEAD2_MASK) == LEAD2_CODE) fresh_run = 2'd1;
    if ((in_byte & LEAD3_MASK) == LEAD3_CODE) fresh_run = 2'd2;
    if ((in_byte & LEAD4_MASK) == LEAD4_CODE) fresh_run = 2'd3;
  end

  always_comb begin
    cmd                = '0;
    lead_held_next     = lead_held;
    run_needed_next    = run_needed;
    run_have_next      = run_have;
    pending_valid_next = pending_valid;
    replaced_flag_next = replaced_flag;
    cont_write         = 1'b0;
    if (end_of_string) begin
      // flush any pending run as replacements, then close the string
      cmd.reps           = flush_reps;
      cmd.end_res        = 1'b1;
      cmd.any            = replaced_flag || pending_valid;
      pending_valid_next = 1'b0;
      run_have_next      = 2'd0;
      run_needed_next    = 2'd0;
      replaced_flag_next = 1'b0;
    end else if (pending_valid && is_cont && (run_have < run_needed)) begin
      if (run_have + 2'd1 == run_needed) begin
        cmd.lit_count      = {1'b0, run_needed} + 3'd1;
        cmd.lits[0]        = lead_held;
        cmd.lits[1]        = (run_have == 2'd0) ? in_byte : cont_bytes[0];
        cmd.lits[2]        = (run_have == 2'd1) ? in_byte : cont_bytes[1];
        cmd.lits[3]        = in_byte;
        pending_valid_next = 1'b0;
        run_have_next      = 2'd0;
        run_needed_next    = 2'd0;
      end else begin
        cont_write    = 1'b1;
        run_have_next = run_have + 2'd1;
      end
    end else begin
      // a broken run is flushed, then the byte is handled fresh
      cmd.reps = flush_reps;
      if (pending_valid) begin
        replaced_flag_next = 1'b1;
        pending_valid_next = 1'b0;
        run_have_next      = 2'd0;
        run_needed_next    = 2'd0;
      end
      if ((in_byte & HIGH_BIT_MASK) == 8'h00) begin
        cmd.lit_count = 3'd1;
        cmd.lits[0]   = in_byte;
      end else if (fresh_run == 2'd0) begin
        cmd.reps           = flush_reps + 3'd1;
        replaced_flag_next = 1'b1;
      end else begin
        lead_held_next     = in_byte;
        run_needed_next    = fresh_run;
        run_have_next      = 2'd0;
        pending_valid_next = 1'b1;
      end
    end
  end

  assign push     = accept && ((cmd.reps != 3'd0) || (cmd.lit_count != 3'd0) || cmd.end_res);
  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_held     <= '0;
      run_needed    <= '0;
      run_have      <= '0;
      pending_valid <= 1'b0;
      replaced_flag <= 1'b0;
    end else if (accept) begin
      lead_held     <= lead_held_next;
      run_needed    <= run_needed_next;
      run_have      <= run_have_next;
      pending_valid <= pending_valid_next;
      replaced_flag <= replaced_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cont_write) begin
      cont_bytes[run_have[0]] <= in_byte;
    end
  end

endmodule

// ===== hw/rtl/ubs_queue.sv =====
// Two-entry command queue between front and back end.
// Entry 0 is always the head. Depends on ubs_pkg.
`timescale 1ns / 1ps

module ubs_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ubs_pkg::cmd_t push_cmd,
  output logic          full,
  output logic          head_valid,
  output ubs_pkg::cmd_t head_cmd,
  input  logic          pop
);
  import ubs_pkg::*;

  cmd_t       slot0;
  cmd_t       slot1;
  logic [1:0] count;

  assign full       = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head_cmd   = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) slot0 <= push_cmd;
        else slot1 <= push_cmd;
      end
      2'b01: begin
        slot0 <= slot1;
      end
      2'b11: begin
        // push only happens when not full, so one entry is in flight
        slot0 <= push_cmd;
      end
      default: begin
        slot0 <= slot0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/ubs_back.sv =====
// Back end: expands the head command into results, one a cycle while the
// output is not stalled, into an output register. Depends on ubs_pkg.
`timescale 1ns / 1ps

module ubs_back (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    repl_byte,
  input  logic          head_valid,
  input  ubs_pkg::cmd_t head_cmd,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          is_end,
  output logic          any_replaced
);
  import ubs_pkg::*;

  logic [1:0] pos;
  logic [2:0] pos_w;
  logic [2:0] total;
  logic [2:0] lit_idx;
  logic       last;
  logic       load;
  logic [7:0] res_byte;
  logic       res_end;
  logic       res_any;

  assign pos_w   = {1'b0, pos};
  assign total   = head_cmd.reps + head_cmd.lit_count + {2'b00, head_cmd.end_res};
  assign last    = pos_w == (total - 3'd1);
  assign lit_idx = pos_w - head_cmd.reps;
  assign load    = head_valid && (!out_valid || !out_stall);
  assign pop     = load && last;

  always_comb begin
    res_byte = 8'h00;
    res_end  = 1'b0;
    res_any  = 1'b0;
    if (pos_w < head_cmd.reps) begin
      res_byte = repl_byte;
    end else if (lit_idx < head_cmd.lit_count) begin
      res_byte = head_cmd.lits[lit_idx[1:0]];
    end else begin
      res_end = 1'b1;
      res_any = head_cmd.any;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= 2'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      pos       <= last ? 2'd0 : pos + 2'd1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte     <= res_byte;
      is_end       <= res_end;
      any_replaced <= res_any;
    end
  end

endmodule
